// ===== hdl/ahfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_pkg: shared types and constants for the ASCII hex frame receiver
// Beat payloads, receive modes, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ahfr_pkg;

  // Timer tick counter width (default for the top level parameter)
  localparam int unsigned TickWidthDef = 32;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegStation = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTimeout = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegMaxLen  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMinLen  = CfgIdxW'(3);

  // Register reset values
  localparam logic [7:0]  StationRst = 8'd0;
  localparam logic [31:0] TimeoutRst = 32'd1000;
  localparam logic [8:0]  MaxLenRst  = 9'd256;
  localparam logic [8:0]  MinLenRst  = 9'd2;

  // Framing characters
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] CaseBit = 8'h20;

  // Request kinds
  localparam logic ReqChar = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ADDR_HI = 3'd1,
    MODE_ADDR_LO = 3'd2,
    MODE_DATA_HI = 3'd3,
    MODE_DATA_LO = 3'd4,
    MODE_CR      = 3'd5
  } rx_mode_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_DROP   = 2'd2
  } frame_event_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
    logic       rx_error;
  } ahfr_in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [7:0] frame_address;
    logic [1:0] frame_event;
    logic [7:0] frame_length;
  } ahfr_out_t;

endpackage

// ===== hdl/ascii_hex_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_unit: ASCII hex framer with LRC check
// Decodes ':' address, hex byte pairs and LRC, then CR LF; filters on the
// station address, emits payload bytes one byte late and reports frame events.
// ----------------------------------------------------------------------------
// Each accepted input beat's result is registered in the output register.
// Throughput: one beat per cycle unless a held result is stalled; the output
// register lets a new beat in while the held result is taken in the same cycle.
// Reset: asynchronous, active low; clears frame state and the output valid and
// loads the configuration registers with their defaults.

module ascii_hex_frame_receiver_unit import ahfr_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TickWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ahfr_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ahfr_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CmpW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

  // Configuration registers
  logic [7:0]  station_q;
  logic [31:0] timeout_q;
  logic [8:0]  max_len_q;
  logic [8:0]  min_len_q;

  // Frame state
  rx_mode_e              mode_q, mode_d;
  logic [7:0]            addr_q, addr_d;
  logic [7:0]            sum_q, sum_d;
  logic [3:0]            hinib_q, hinib_d;
  logic [7:0]            held_q, held_d;
  logic                  held_vld_q, held_vld_d;
  logic [8:0]            cnt_q, cnt_d;
  logic [TICK_WIDTH-1:0] ticks_q, ticks_d;

  // Output register
  logic      out_vld_q;
  ahfr_out_t out_q;
  ahfr_out_t res;

  logic                  accept;
  logic [TICK_WIDTH-1:0] ticks_inc;
  logic [CmpW-1:0]       ticks_cmp;
  logic [CmpW-1:0]       timeout_cmp;
  logic                  is_hex;
  logic [3:0]            nib;
  logic [7:0]            ch_low;
  logic [7:0]            addr_new;
  logic [7:0]            byte_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_vld_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= StationRst;
      timeout_q <= TimeoutRst;
      max_len_q <= MaxLenRst;
      min_len_q <= MinLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStation: station_q <= cfg_data_i[7:0];
        RegTimeout: timeout_q <= cfg_data_i[31:0];
        RegMaxLen:  max_len_q <= cfg_data_i[8:0];
        RegMinLen:  min_len_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Decode one hex digit, either case
  always_comb begin
    ch_low = in_data_i.rx_char | CaseBit;
    is_hex = 1'b0;
    nib    = 4'd0;
    if (in_data_i.rx_char >= 8'h30 && in_data_i.rx_char <= 8'h39) begin
      is_hex = 1'b1;
      nib    = in_data_i.rx_char[3:0];
    end else if (ch_low >= 8'h61 && ch_low <= 8'h66) begin
      is_hex = 1'b1;
      nib    = 4'(ch_low - 8'h57);
    end
  end

  // Saturating tick count and timeout compare
  assign ticks_inc   = (ticks_q == {TICK_WIDTH{1'b1}}) ? ticks_q : ticks_q + 1'b1;
  assign ticks_cmp   = CmpW'(ticks_inc);
  assign timeout_cmp = CmpW'(timeout_q);
  assign addr_new    = {addr_q[3:0], nib};
  assign byte_new    = {hinib_q, nib};

  // Next frame state and result for the beat on the input
  always_comb begin
    mode_d     = mode_q;
    addr_d     = addr_q;
    sum_d      = sum_q;
    hinib_d    = hinib_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    cnt_d      = cnt_q;
    ticks_d    = ticks_q;
    res        = '0;

    priority if (in_data_i.req_type == ReqTick) begin
      if (mode_q != MODE_IDLE) begin
        ticks_d = ticks_inc;
        if (ticks_cmp > timeout_cmp) begin
          res.frame_event = EV_DROP;
          mode_d          = MODE_IDLE;
          held_vld_d      = 1'b0;
          ticks_d         = '0;
        end
      end
    end else if (mode_q == MODE_IDLE) begin
      // Start a frame on a clean start mark
      if (!in_data_i.rx_error && in_data_i.rx_char == ChColon) begin
        mode_d     = MODE_ADDR_HI;
        addr_d     = '0;
        held_vld_d = 1'b0;
        ticks_d    = '0;
      end
    end else if (in_data_i.rx_error) begin
      res.frame_event = EV_DROP;
      mode_d          = MODE_IDLE;
      held_vld_d      = 1'b0;
      ticks_d         = '0;
    end else if (in_data_i.rx_char == ChColon) begin
      // Abandon the frame and restart
      res.frame_event = EV_DROP;
      mode_d          = MODE_ADDR_HI;
      addr_d          = '0;
      held_vld_d      = 1'b0;
      ticks_d         = '0;
    end else if (mode_q == MODE_CR) begin
      if (in_data_i.rx_char == ChLf && cnt_q >= min_len_q && sum_q == 8'd0) begin
        res.frame_event  = EV_ACCEPT;
        res.frame_length = (cnt_q != 9'd0) ? 8'(cnt_q - 9'd1) : 8'd0;
      end else begin
        res.frame_event = EV_DROP;
      end
      mode_d     = MODE_IDLE;
      held_vld_d = 1'b0;
      ticks_d    = '0;
    end else if (in_data_i.rx_char == ChCr &&
                 (mode_q == MODE_DATA_HI || mode_q == MODE_DATA_LO)) begin
      if (mode_q == MODE_DATA_HI) begin
        mode_d  = MODE_CR;
        ticks_d = '0;
      end else begin
        res.frame_event = EV_DROP;
        mode_d          = MODE_IDLE;
        held_vld_d      = 1'b0;
        ticks_d         = '0;
      end
    end else if (!is_hex) begin
      res.frame_event = EV_DROP;
      mode_d          = MODE_IDLE;
      held_vld_d      = 1'b0;
      ticks_d         = '0;
    end else begin
      unique case (mode_q)
        MODE_ADDR_HI: begin
          addr_d  = {4'd0, nib};
          mode_d  = MODE_ADDR_LO;
          ticks_d = '0;
        end
        MODE_ADDR_LO: begin
          addr_d     = addr_new;
          ticks_d    = '0;
          held_vld_d = 1'b0;
          // Ignore frames for another station
          if (station_q != 8'd0 && addr_new != 8'd0 && station_q != addr_new) begin
            mode_d = MODE_IDLE;
          end else begin
            sum_d  = addr_new;
            cnt_d  = '0;
            mode_d = MODE_DATA_HI;
          end
        end
        MODE_DATA_HI: begin
          if (cnt_q >= max_len_q) begin
            res.frame_event = EV_DROP;
            mode_d          = MODE_IDLE;
            held_vld_d      = 1'b0;
            ticks_d         = '0;
          end else begin
            hinib_d = nib;
            mode_d  = MODE_DATA_LO;
            ticks_d = '0;
          end
        end
        default: begin
          // Release the held byte, hold back the new one
          if (held_vld_q) begin
            res.byte_valid = 1'b1;
            res.data_byte  = held_q;
          end
          held_d     = byte_new;
          held_vld_d = 1'b1;
          sum_d      = sum_q + byte_new;
          if (cnt_q != 9'h1FF) begin
            cnt_d = cnt_q + 9'd1;
          end
          mode_d  = MODE_DATA_HI;
          ticks_d = '0;
        end
      endcase
    end

    res.frame_address = addr_d;
  end

  // Advance frame state on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      addr_q     <= '0;
      sum_q      <= '0;
      hinib_q    <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      cnt_q      <= '0;
      ticks_q    <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      addr_q     <= addr_d;
      sum_q      <= sum_d;
      hinib_q    <= hinib_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      cnt_q      <= cnt_d;
      ticks_q    <= ticks_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule

// ===== hdl/ahfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_checker: port-level checks for the ASCII hex frame receiver
// Watches the result channel and the input backpressure of the top level.
// ----------------------------------------------------------------------------
module ahfr_checker import ahfr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ahfr_out_t out_data_o
);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Input stalls only behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // No data without its valid flag
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.data_byte == 8'd0)
    else $error("data byte set without byte valid");

  // Length only with an accepted frame
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_event != EV_ACCEPT |-> out_data_o.frame_length == 8'd0)
    else $error("frame length set without accept");

  // Bytes are never released together with a frame end
  a_byte_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.frame_event == EV_NONE)
    else $error("byte released with a frame event");

endmodule

bind ascii_hex_frame_receiver_unit ahfr_checker u_ahfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== bench/tb_ascii_hex_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_hex_frame_receiver_unit: self-checking bench for the hex framer
// Drives character and tick beats with random gaps and output stalls, runs
// through several register settings, predicts every result beat in a
// scoreboard and compares each field of each accepted result against it.
// ----------------------------------------------------------------------------

module tb_ascii_hex_frame_receiver_unit;
  import ahfr_pkg::*;

  localparam int unsigned TickW      = TickWidthDef;
  localparam logic [63:0] TickMax    = (TickW >= 64) ? '1 : ((64'd1 << TickW) - 64'd1);
  localparam time         RunLimitNs = 20_000_000;

  // Predict the framer and hold the result beats it still owes
  class frame_scoreboard;
    logic [7:0]  station;
    logic [31:0] timeout;
    logic [8:0]  max_len;
    logic [8:0]  min_len;
    rx_mode_e    mode;
    logic [7:0]  addr;
    logic [7:0]  sum;
    logic [7:0]  held;
    logic        held_ok;
    logic [3:0]  hi_nib;
    logic [8:0]  count;
    logic [63:0] ticks;
    ahfr_out_t   owed_results[$];
    int unsigned mismatches;

    function new();
      station    = StationRst;
      timeout    = TimeoutRst;
      max_len    = MaxLenRst;
      min_len    = MinLenRst;
      mode       = MODE_IDLE;
      addr       = '0;
      sum        = '0;
      held       = '0;
      held_ok    = 1'b0;
      hi_nib     = '0;
      count      = '0;
      ticks      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegStation: station = val[7:0];
        RegTimeout: timeout = val[31:0];
        RegMaxLen:  max_len = val[8:0];
        RegMinLen:  min_len = val[8:0];
        default: ;
      endcase
    endfunction

    // Bit 4 flags a character that is not a hex digit
    function logic [4:0] hex_nibble(logic [7:0] c);
      logic [7:0] low;
      if (c >= "0" && c <= "9") begin
        return {1'b0, 4'(c - "0")};
      end
      low = c | CaseBit;
      if (low >= "a" && low <= "f") begin
        return {1'b0, 4'(low - "a" + 8'd10)};
      end
      return 5'h10;
    endfunction

    function frame_event_e drop_frame();
      mode    = MODE_IDLE;
      held_ok = 1'b0;
      ticks   = '0;
      return EV_DROP;
    endfunction

    function void open_frame();
      mode    = MODE_ADDR_HI;
      addr    = '0;
      held_ok = 1'b0;
      ticks   = '0;
    endfunction

    // Advance the framer by one input beat; return 0 if the beat was ignored
    function bit receive_beat(ahfr_in_t b);
      ahfr_out_t    r;
      frame_event_e ev;
      logic [4:0]   nib;
      bit           live;
      r    = '0;
      ev   = EV_NONE;
      live = (mode != MODE_IDLE);
      nib  = hex_nibble(b.rx_char);
      if (b.req_type == ReqTick) begin
        if (mode != MODE_IDLE) begin
          if (ticks < TickMax) ticks++;
          if (ticks > 64'(timeout)) ev = drop_frame();
        end
      end else if (mode == MODE_IDLE) begin
        if (!b.rx_error && b.rx_char == ChColon) begin
          open_frame();
          live = 1'b1;
        end
      end else if (b.rx_error) begin
        ev = drop_frame();
      end else if (b.rx_char == ChColon) begin
        ev = EV_DROP;
        open_frame();
      end else if (mode == MODE_CR) begin
        if (b.rx_char == ChLf && count >= min_len && sum == 8'd0) begin
          ev              = EV_ACCEPT;
          r.frame_length  = (count != 9'd0) ? 8'(count - 9'd1) : 8'd0;
          mode            = MODE_IDLE;
          held_ok         = 1'b0;
          ticks           = '0;
        end else begin
          ev = drop_frame();
        end
      end else if (b.rx_char == ChCr && (mode == MODE_DATA_HI || mode == MODE_DATA_LO)) begin
        if (mode == MODE_DATA_HI) begin
          mode  = MODE_CR;
          ticks = '0;
        end else begin
          ev = drop_frame();
        end
      end else if (nib[4]) begin
        ev = drop_frame();
      end else begin
        case (mode)
          MODE_ADDR_HI: begin
            addr  = {4'd0, nib[3:0]};
            mode  = MODE_ADDR_LO;
            ticks = '0;
          end
          MODE_ADDR_LO: begin
            addr    = {addr[3:0], nib[3:0]};
            ticks   = '0;
            held_ok = 1'b0;
            // Skip frames for other stations without an event
            if (station != 8'd0 && addr != 8'd0 && station != addr) begin
              mode = MODE_IDLE;
            end else begin
              sum   = addr;
              count = '0;
              mode  = MODE_DATA_HI;
            end
          end
          MODE_DATA_HI: begin
            if (count >= max_len) begin
              ev = drop_frame();
            end else begin
              hi_nib = nib[3:0];
              mode   = MODE_DATA_LO;
              ticks  = '0;
            end
          end
          default: begin
            // Release the byte held back, then hold the new one
            if (held_ok) begin
              r.byte_valid = 1'b1;
              r.data_byte  = held;
            end
            held    = {hi_nib, nib[3:0]};
            held_ok = 1'b1;
            sum     = sum + held;
            if (count != 9'h1FF) count++;
            mode  = MODE_DATA_HI;
            ticks = '0;
          end
        endcase
      end
      r.frame_address = addr;
      r.frame_event   = ev;
      owed_results.push_back(r);
      return live;
    endfunction

    function void flag(string what, ahfr_out_t want, ahfr_out_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected valid=%0d byte=%02h addr=%02h event=%0d len=%0d",
                 $time, what, want.byte_valid, want.data_byte, want.frame_address,
                 want.frame_event, want.frame_length);
        $display("%0t %s:      got valid=%0d byte=%02h addr=%02h event=%0d len=%0d",
                 $time, what, got.byte_valid, got.data_byte, got.frame_address,
                 got.frame_event, got.frame_length);
      end
    endfunction

    function void check_result(ahfr_out_t got);
      ahfr_out_t want;
      if (owed_results.size() == 0) begin
        flag("result beat with nothing owed", '0, got);
        return;
      end
      want = owed_results.pop_front();
      if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
          got.frame_address !== want.frame_address ||
          got.frame_event !== want.frame_event || got.frame_length !== want.frame_length) begin
        flag("result mismatch", want, got);
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  ahfr_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ahfr_out_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  frame_scoreboard sb = new();
  ahfr_in_t        frame_q[$];
  bit              steady;
  int              live_beats;

  ascii_hex_frame_receiver_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while steady
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Take result beats and stall the output side at random
  initial begin
    bit        take;
    ahfr_out_t snap;
    int        stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      take = out_valid_o && out_ready_i;
      snap = out_data_o;
      @(posedge clk_i);
      if (take) sb.check_result(snap);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall = idle_gap();
        out_ready_i <= (stall == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one input beat and hold it until accepted
  task automatic send_beat(ahfr_in_t b);
    int gap;
    bit acc;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    if (sb.receive_beat(b)) live_beats++;
  endtask

  // Write all four registers back to back while the framer is idle
  task automatic set_config(logic [7:0] station, logic [31:0] timeout,
                            logic [8:0] max_len, logic [8:0] min_len);
    logic [CfgDataW-1:0] vals[4];
    bit                  acc;
    vals = '{CfgDataW'(station), CfgDataW'(timeout), CfgDataW'(max_len), CfgDataW'(min_len)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= vals[i];
      do begin
        @(negedge clk_i);
        acc = cfg_ready_o;
        @(posedge clk_i);
      end while (!acc);
      sb.write_reg(CfgIdxW'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering beats and wait until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) return "0" + 8'(n);
    c = "A" + 8'(n) - 8'd10;
    if ($urandom_range(0, 1) != 0) c = c | CaseBit;
    return c;
  endfunction

  function automatic ahfr_in_t tick_beat();
    ahfr_in_t t;
    t.req_type = ReqTick;
    t.rx_char  = 8'($urandom);
    t.rx_error = 1'($urandom);
    return t;
  endfunction

  function automatic void push_char(logic [7:0] c, logic err = 1'b0);
    ahfr_in_t t;
    t.req_type = ReqChar;
    t.rx_char  = c;
    t.rx_error = err;
    frame_q.push_back(t);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    push_char(hex_digit(b[7:4]));
    push_char(hex_digit(b[3:0]));
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_char(s[i]);
  endfunction

  function automatic void push_ticks(int n);
    repeat (n) frame_q.push_back(tick_beat());
  endfunction

  // Build ':' address, n random bytes, LRC, CR LF
  function automatic void make_frame(logic [7:0] addr, int n, bit bad_lrc);
    logic [7:0] s;
    logic [7:0] b;
    logic [7:0] lrc;
    frame_q.delete();
    push_char(ChColon);
    push_byte(addr);
    s = addr;
    repeat (n) begin
      b = 8'($urandom);
      push_byte(b);
      s = s + b;
    end
    lrc = -s;
    if (bad_lrc) lrc = lrc ^ 8'($urandom_range(1, 255));
    push_byte(lrc);
    push_char(ChCr);
    push_char(ChLf);
  endfunction

  // Send the built beats, optionally with stray ticks in between
  task automatic send_frame(bit sprinkle);
    foreach (frame_q[i]) begin
      if (sprinkle && !steady && $urandom_range(0, 19) == 0) send_beat(tick_beat());
      send_beat(frame_q[i]);
    end
    frame_q.delete();
  endtask

  // Mostly well-formed frames, some with one flaw, some pure noise
  task automatic random_frame();
    logic [7:0] addr;
    ahfr_in_t   t;
    int         n;
    int         flaw;
    int         pos;
    int         r;
    int         k;
    bit         short_to;
    steady   = ($urandom_range(0, 9) == 0);
    short_to = (sb.timeout <= 32'd64);
    if ($urandom_range(0, 9) == 0) begin
      frame_q.delete();
      repeat ($urandom_range(1, 6)) begin
        t.req_type = 1'($urandom);
        t.rx_char  = 8'($urandom);
        t.rx_error = ($urandom_range(0, 3) == 0);
        frame_q.push_back(t);
      end
      send_frame(1'b0);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 40) addr = sb.station;
    else if (r < 60) addr = 8'd0;
    else addr = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 85) n = $urandom_range(0, 6);
    else if (r < 98) n = $urandom_range(7, 30);
    else n = $urandom_range(0, int'(sb.max_len));
    flaw = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 7);
    make_frame(addr, n, flaw == 1);
    pos = $urandom_range(1, frame_q.size() - 1);
    case (flaw)
      2: frame_q[pos].rx_char = 8'($urandom);
      3: frame_q[pos].rx_error = 1'b1;
      4: begin
        t.req_type = ReqChar;
        t.rx_char  = ChColon;
        t.rx_error = 1'b0;
        frame_q.insert(pos, t);
      end
      5: frame_q.delete(pos);
      6: begin
        // Cut the frame short and let the timer run around its limit
        while (frame_q.size() > pos) void'(frame_q.pop_back());
        k = short_to ? $urandom_range(int'(sb.timeout), int'(sb.timeout) + 1) : 2;
        push_ticks(k);
      end
      7: begin
        k = short_to ? $urandom_range(1, int'(sb.timeout) + 1) : $urandom_range(1, 3);
        repeat (k) frame_q.insert(pos, tick_beat());
      end
      default: ;
    endcase
    send_frame(1'b1);
  endtask

  task automatic run_random(int target);
    int start;
    start = live_beats;
    while (live_beats - start < target) random_frame();
  endtask

  // Hard stop if the bench hangs
  initial begin
    #(RunLimitNs);
    $display("** ascii_hex_frame_receiver_unit: FAILED **");
    $finish;
  end

  initial begin
    live_beats = 0;
    steady     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: ignored beats in idle, good frame, restart, errors, bad ends
    frame_q.delete();
    push_char(8'h00, 1'b1);
    push_char(8'hFF);
    frame_q.push_back(tick_beat());
    push_char(ChColon, 1'b1);
    push_text(":ff0100");
    push_char(ChCr);
    push_char(ChLf);
    push_text(":1:G");
    push_char(ChColon);
    push_char("A", 1'b1);
    push_text(":00a");
    push_char(ChCr);
    push_text(":0001");
    push_char(ChCr);
    push_char(ChLf);
    push_text(":00");
    push_char(ChCr);
    push_char(ChLf);
    push_char(ChColon);
    push_char(ChCr);
    send_frame(1'b0);
    run_random(130);
    drain();

    // Own station, shortest timeout, smallest frames
    set_config(8'h5A, 32'd1, 9'd3, 9'd0);
    frame_q.delete();
    push_text(":12");
    push_text(":00");
    push_char(ChCr);
    push_char(ChLf);
    push_text(":5a010203a");
    push_text(":5A");
    push_ticks(2);
    send_frame(1'b0);
    run_random(90);
    drain();

    // Top station, timer never expires, full-size frames only
    set_config(8'hFF, 32'hFFFF_FFFF, 9'd256, 9'd256);
    make_frame(8'hFF, 255, 1'b0);
    send_frame(1'b0);
    run_random(50);
    drain();

    // Promiscuous with short random limits
    set_config(8'd0, 32'($urandom_range(2, 20)), 9'($urandom_range(3, 40)),
               9'($urandom_range(0, 5)));
    run_random(150);
    drain();

    // Random own station, very short timeouts
    set_config(8'($urandom_range(1, 254)), 32'($urandom_range(1, 8)), 9'd256, 9'd2);
    run_random(120);
    drain();

    // Back to defaults
    set_config(StationRst, TimeoutRst, MaxLenRst, MinLenRst);
    run_random(110);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** ascii_hex_frame_receiver_unit: PASSED **");
    end else begin
      $display("** ascii_hex_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

endmodule
